[src/psa_pkg.sv]
// Shared types, codes and reset constants of the priority slot allocator.
package psa_pkg;

  localparam int SLOTS_DEF = 8;

  localparam logic [3:0]  ACTIVE_RESET = 4'd8;
  localparam logic [15:0] WTHR_RESET   = 16'd2;
  localparam logic [16:0] AGE_MAX      = 17'h1FFFF;

  // Configuration register indexes
  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_WTHR   = 1'b1;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_BAD    = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_INVALID  = 3'd1,
    ST_NOSLOT   = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_TICK     = 3'd5
  } status_t;

  // Request fields broadcast to every cell during a sweep
  typedef struct packed {
    act_t        op;
    logic [31:0] handle;
  } req_t;

  // Slot write broadcast at commit
  typedef struct packed {
    logic        en;
    logic [15:0] lifetime;
    logic [15:0] prio;
    logic [31:0] handle;
  } wr_t;

  // Running search results handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        have_dead;
    logic        have_min;
    logic [15:0] minp;
    logic        hit;
    logic        alive;
    logic [16:0] age;
  } pkt_t;

endpackage

[src/psa_cell.sv]
// One slot of the allocator: slot state plus one stage of the search chain.
module psa_cell import psa_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDX   = 0,
  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [3:0]    active_slots_i,
  input  req_t          req_i,
  input  wr_t           wr_i,
  input  logic [IW-1:0] wr_idx_i,
  input  pkt_t          pkt_i,
  input  logic [IW-1:0] dead_idx_i,
  input  logic [IW-1:0] min_idx_i,
  input  logic [IW-1:0] hit_idx_i,
  output pkt_t          pkt_o,
  output logic [IW-1:0] dead_idx_o,
  output logic [IW-1:0] min_idx_o,
  output logic [IW-1:0] hit_idx_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [15:0]   life_r;
  logic [15:0]   prio_r;
  logic [31:0]   hand_r;
  logic [16:0]   age_r;
  pkt_t          pkt_r;
  pkt_t          pkt_nxt;
  logic [IW-1:0] dead_idx_r, dead_idx_nxt;
  logic [IW-1:0] min_idx_r, min_idx_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic          active;
  logic          do_tick;
  logic          do_wr;
  logic [16:0]   age_inc;

  assign active  = 32'(IDX) < {28'd0, active_slots_i};
  assign do_tick = pkt_i.valid && (req_i.op == ACT_TICK) && active && (life_r != 16'd0);
  assign do_wr   = wr_i.en && (wr_idx_i == MY_IDX);
  assign age_inc = (age_r < AGE_MAX) ? age_r + 17'd1 : age_r;

  always_comb begin
    pkt_nxt      = pkt_i;
    dead_idx_nxt = dead_idx_i;
    min_idx_nxt  = min_idx_i;
    hit_idx_nxt  = hit_idx_i;
    unique case (req_i.op)
      ACT_ADD: begin
        if (active && !pkt_i.have_dead && (life_r == 16'd0)) begin
          pkt_nxt.have_dead = 1'b1;
          dead_idx_nxt      = MY_IDX;
        end
        // strictly lower keeps the first of equal minima
        if (active && (prio_r < pkt_i.minp)) begin
          pkt_nxt.have_min = 1'b1;
          pkt_nxt.minp     = prio_r;
          min_idx_nxt      = MY_IDX;
        end
      end
      ACT_LOOKUP: begin
        if (!pkt_i.hit && (hand_r == req_i.handle)) begin
          pkt_nxt.hit   = 1'b1;
          pkt_nxt.alive = (life_r != 16'd0);
          pkt_nxt.age   = age_r;
          hit_idx_nxt   = MY_IDX;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r <= '0;
      prio_r <= '0;
      hand_r <= '0;
      age_r  <= '0;
    end else if (do_wr) begin
      life_r <= wr_i.lifetime;
      prio_r <= wr_i.prio;
      hand_r <= wr_i.handle;
      age_r  <= '0;
    end else if (do_tick) begin
      age_r <= age_inc;
      if (age_inc > {1'b0, life_r}) begin
        life_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.valid <= 1'b0;
    end else begin
      pkt_r.valid <= pkt_i.valid;
    end
    pkt_r.have_dead <= pkt_nxt.have_dead;
    pkt_r.have_min  <= pkt_nxt.have_min;
    pkt_r.minp      <= pkt_nxt.minp;
    pkt_r.hit       <= pkt_nxt.hit;
    pkt_r.alive     <= pkt_nxt.alive;
    pkt_r.age       <= pkt_nxt.age;
    dead_idx_r      <= dead_idx_nxt;
    min_idx_r       <= min_idx_nxt;
    hit_idx_r       <= hit_idx_nxt;
  end

  assign pkt_o      = pkt_r;
  assign dead_idx_o = dead_idx_r;
  assign min_idx_o  = min_idx_r;
  assign hit_idx_o  = hit_idx_r;

endmodule

[src/priority_slot_allocator.sv]
// Top level of the priority slot allocator: request control, cell chain and result register.
//
// Usage:
//   Input channel (in_*): one request per handshake, taken when in_valid is high and
//   in_stall is low. in_action selects add (0), frame tick (1) or handle lookup (2);
//   action 3 answers "invalid". Every request yields exactly one result.
//   Result channel (out_*): out_valid holds with a steady payload until out_stall is low.
//   Configuration (cfg_*): cfg_index 0 = active_slots, 1 = weight_threshold; cfg_ready is
//   always high. Write only while no request is in flight.
// Timing:
//   A request travels the chain of SLOTS cells, one cell per cycle. A checked add, a tick
//   or a lookup is launched from a register, swept through the cells and captured at the
//   chain end before its result is loaded; a rejected add or action 3 skips the sweep.
//   The next request is taken only once the result is loaded; requests do not overlap.
// Reset:
//   rst_n (synchronous, active low) kills every slot, zeroes handles and ages, clears the
//   handle counter and loads active_slots = 8, weight_threshold = 2.
// Stall:
//   A stalled result holds in the output register; a request taken meanwhile runs its
//   sweep and waits at the chain end until the register frees up.
module priority_slot_allocator import psa_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [15:0]        in_lifetime,
  input  logic [15:0]        in_priority_req,
  input  logic signed [15:0] in_radius,
  input  logic [15:0]        in_weight_sq,
  input  logic [31:0]        in_handle,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [2:0]         out_slot,
  output logic [31:0]        out_handle,
  output logic               out_alive,
  output logic [16:0]        out_age,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t        state_r;

  // configuration registers
  logic [3:0]    active_slots_r;
  logic [15:0]   wthr_r;

  // request held for the whole sweep
  act_t          req_op_r;
  logic [15:0]   req_life_r;
  logic [15:0]   req_prio_r;
  logic [31:0]   req_handle_r;
  logic          bad_r;
  logic          launch_r;

  logic [31:0]   next_handle_r;

  // chain end, captured when the sweep leaves the last cell
  pkt_t          tail_r;
  logic [IW-1:0] tail_dead_r, tail_min_r, tail_hit_r;

  // output register
  logic          out_valid_r;
  status_t       out_status_r;
  logic [2:0]    out_slot_r;
  logic [31:0]   out_handle_r;
  logic          out_alive_r;
  logic [16:0]   out_age_r;

  // chain wiring
  pkt_t          pkt_c  [SLOTS+1];
  logic [IW-1:0] dead_c [SLOTS+1];
  logic [IW-1:0] min_c  [SLOTS+1];
  logic [IW-1:0] hit_c  [SLOTS+1];

  req_t          req_b;
  wr_t           wr_b;
  logic [IW-1:0] wr_idx;

  logic          in_acc;
  logic          in_bad;
  logic          out_free;
  logic          load_out;

  status_t       res_status;
  logic [IW-1:0] res_idx;
  logic [31:0]   res_handle;
  logic          res_alive;
  logic [16:0]   res_age;
  logic          res_commit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // reject action 3, and any add that fails its entry checks
  always_comb begin
    in_bad = 1'b0;
    unique case (act_t'(in_action))
      ACT_ADD: begin
        in_bad = (in_lifetime == 16'd0) || (in_radius == 16'sd0) || in_radius[15] ||
                 (in_weight_sq <= wthr_r);
      end
      ACT_TICK, ACT_LOOKUP: begin
        in_bad = 1'b0;
      end
      ACT_BAD: begin
        in_bad = 1'b1;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_slots_r <= ACTIVE_RESET;
      wthr_r         <= WTHR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACTIVE: active_slots_r <= cfg_data[3:0];
        CFG_WTHR:   wthr_r         <= cfg_data;
      endcase
    end
  end

  // launch packet: nothing found yet, minimum starts at the requested priority
  always_comb begin
    pkt_c[0].valid     = launch_r;
    pkt_c[0].have_dead = 1'b0;
    pkt_c[0].have_min  = 1'b0;
    pkt_c[0].minp      = req_prio_r;
    pkt_c[0].hit       = 1'b0;
    pkt_c[0].alive     = 1'b0;
    pkt_c[0].age       = '0;
    dead_c[0]          = '0;
    min_c[0]           = '0;
    hit_c[0]           = '0;
  end

  assign req_b.op     = req_op_r;
  assign req_b.handle = req_handle_r;

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      psa_cell #(
        .SLOTS (SLOTS),
        .IDX   (g)
      ) u_cell (
        .clk            (clk),
        .rst_n          (rst_n),
        .active_slots_i (active_slots_r),
        .req_i          (req_b),
        .wr_i           (wr_b),
        .wr_idx_i       (wr_idx),
        .pkt_i          (pkt_c[g]),
        .dead_idx_i     (dead_c[g]),
        .min_idx_i      (min_c[g]),
        .hit_idx_i      (hit_c[g]),
        .pkt_o          (pkt_c[g+1]),
        .dead_idx_o     (dead_c[g+1]),
        .min_idx_o      (min_c[g+1]),
        .hit_idx_o      (hit_c[g+1])
      );
    end
  endgenerate

  // decide the result from the captured chain end
  always_comb begin
    res_status = ST_INVALID;
    res_idx    = '0;
    res_handle = '0;
    res_alive  = 1'b0;
    res_age    = '0;
    res_commit = 1'b0;
    if (!bad_r) begin
      unique case (req_op_r)
        ACT_ADD: begin
          // a dead slot wins over eviction
          priority if (tail_r.have_dead) begin
            res_status = ST_ADDED;
            res_idx    = tail_dead_r;
            res_commit = 1'b1;
          end else if (tail_r.have_min) begin
            res_status = ST_ADDED;
            res_idx    = tail_min_r;
            res_commit = 1'b1;
          end else begin
            res_status = ST_NOSLOT;
          end
          if (res_commit) begin
            res_handle = next_handle_r;
            res_alive  = 1'b1;
          end
        end
        ACT_TICK: begin
          res_status = ST_TICK;
        end
        ACT_LOOKUP: begin
          if (tail_r.hit) begin
            res_status = ST_FOUND;
            res_idx    = tail_hit_r;
            res_handle = req_handle_r;
            res_alive  = tail_r.alive;
            res_age    = tail_r.age;
          end else begin
            res_status = ST_NOTFOUND;
          end
        end
        ACT_BAD: begin
          res_status = ST_INVALID;
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == S_DONE) && out_free;

  // commit the add into its slot as the result is loaded
  assign wr_b.en       = load_out && res_commit;
  assign wr_b.lifetime = req_life_r;
  assign wr_b.prio     = req_prio_r;
  assign wr_b.handle   = next_handle_r;
  assign wr_idx        = res_idx;

  // request capture, sweep tracking and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      launch_r      <= 1'b0;
      next_handle_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      launch_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_bad) begin
              state_r <= S_DONE;
            end else begin
              state_r  <= S_SWEEP;
              launch_r <= 1'b1;
            end
          end
        end
        S_SWEEP: begin
          if (pkt_c[SLOTS].valid) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (res_commit) begin
              next_handle_r <= next_handle_r + 32'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    if (in_acc) begin
      req_op_r     <= act_t'(in_action);
      req_life_r   <= in_lifetime;
      req_prio_r   <= in_priority_req;
      req_handle_r <= in_handle;
      bad_r        <= in_bad;
    end
    if (pkt_c[SLOTS].valid) begin
      tail_r      <= pkt_c[SLOTS];
      tail_dead_r <= dead_c[SLOTS];
      tail_min_r  <= min_c[SLOTS];
      tail_hit_r  <= hit_c[SLOTS];
    end
    if (load_out) begin
      out_status_r <= res_status;
      out_slot_r   <= 3'(res_idx);
      out_handle_r <= res_handle;
      out_alive_r  <= res_alive;
      out_age_r    <= res_age;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_handle = out_handle_r;
  assign out_alive  = out_alive_r;
  assign out_age    = out_age_r;

endmodule
